/* rtl/ktlfm_pkg.sv */
// package: item types, codes, control and status structs for the key trail fade map
`timescale 1ns / 1ps

package ktlfm_pkg;

    // matrix size defaults
    localparam int DEF_ROW_COUNT = 4;
    localparam int DEF_COL_COUNT = 16;

    // reset value of the step interval
    localparam logic [15:0] DEF_STEP_MS = 16'd50;

    // full brightness level of a pressed key
    localparam logic [7:0] LEVEL_FULL = 8'hff;

    // action codes
    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_FRAME = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_RED    = 3'd1;
    localparam logic [2:0] REG_GREEN  = 3'd2;
    localparam logic [2:0] REG_BLUE   = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;

    // input item
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  key_row;
        logic [4:0]  key_col;
        logic        pressed;
        logic [15:0] now_ms;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0] led_row;
        logic [3:0] led_col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic key_event;
        logic clear;
        logic frame_start;
        logic issue;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic enable;
        logic pipe_busy;
        logic advance;
        logic at_last;
    } t_status;

endpackage

/* rtl/key_trail_led_fade_map.sv */
// top level: key trail fade map, controller plus datapath
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in (t_in_item)
//  out     | output    | o_out_valid/i_out_ready | o_out (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// key, clear and ignored items need no walk; a frame item walks ROW_COUNT*COL_COUNT
// cells, one per cycle while the output is not stalled, through a read, a
// decay/multiply and a divide/output stage; the next item waits for the last write-back.
// the walk rate is set by the single read and write port of the level memory.
// a stalled output freezes the whole cell pipeline; no item is lost.
// reset (synchronous, active low) clears the level valid bits at once, no clearing pass.
`timescale 1ns / 1ps

module key_trail_led_fade_map
    import ktlfm_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int COL_COUNT = DEF_COL_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // controller
    ktlfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_in.action),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    ktlfm_dp #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/ktlfm_ctrl.sv */
// controller: accepts items and sequences the cell walk of a frame
`timescale 1ns / 1ps

module ktlfm_ctrl
    import ktlfm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  t_status    i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // take an item only when the previous walk has finished its write-back
    assign o_in_ready = (r_state == ST_IDLE) && !i_sts.pipe_busy;
    assign accept     = i_in_valid && o_in_ready;

    // commands
    always_comb begin
        o_cmd.key_event   = accept && (i_action == ACT_KEY);
        o_cmd.clear       = accept && (i_action == ACT_CLEAR);
        o_cmd.frame_start = accept && (i_action == ACT_FRAME) && i_sts.enable;
        o_cmd.issue       = (r_state == ST_WALK) && i_sts.advance;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.frame_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.issue && i_sts.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/ktlfm_dp.sv */
// datapath: configuration, level memory, decay and colour scaling pipeline
`timescale 1ns / 1ps

module ktlfm_dp
    import ktlfm_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int COL_COUNT = DEF_COL_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_in_item    i_in,
    input  t_cmd        i_cmd,
    output t_status     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int MAP_DEPTH = ROW_COUNT * COL_COUNT;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // one decay step of a level
    function automatic logic [7:0] decay(input logic [7:0] v);
        logic [7:0] res;
        if (v >= 8'hf0) begin
            res = v - 8'd1;
        end else if (v >= 8'h40) begin
            res = v - 8'd16;
        end else if (v >= 8'd32) begin
            res = v - 8'd32;
        end else begin
            res = 8'd0;
        end
        return res;
    endfunction

    // floor of x / 255, exact for x up to 255*255 (any 8x8-bit product)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

    // configuration registers
    logic        r_enable;
    logic [7:0]  r_hl_red;
    logic [7:0]  r_hl_green;
    logic [7:0]  r_hl_blue;
    logic [15:0] r_step_ms;
    logic [15:0] r_last_step;
    logic        r_do_step;

    // walk counters
    logic [1:0]    r_row;
    logic [3:0]    r_col;
    logic [AW-1:0] r_addr;

    // level memory and valid bits
    logic [7:0]           r_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_vld;

    // stage 1: read data
    logic          r_s1_valid;
    logic          r_s1_hit;
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_s1_addr;
    logic [1:0]    r_s1_row;
    logic [3:0]    r_s1_col;
    logic          r_s1_last;

    // stage 2: products
    logic        r_s2_valid;
    logic        r_s2_black;
    logic [15:0] r_prod_red;
    logic [15:0] r_prod_green;
    logic [15:0] r_prod_blue;
    logic [1:0]  r_s2_row;
    logic [3:0]  r_s2_col;
    logic        r_s2_last;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic          advance;
    logic          at_last;
    logic [15:0]   elapsed;
    logic [7:0]    key_idx;
    logic          key_hit;
    logic [7:0]    s1_level;
    logic [7:0]    s1_after;
    logic          s1_wr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // pipeline moves whenever the output register is free or being taken
    assign advance = !r_out_valid || i_out_ready;
    assign at_last = (r_row == 2'(ROW_COUNT - 1)) && (r_col == 4'(COL_COUNT - 1));
    assign elapsed = i_in.now_ms - r_last_step;

    always_comb begin
        o_sts.enable    = r_enable;
        o_sts.pipe_busy = r_s1_valid;
        o_sts.advance   = advance;
        o_sts.at_last   = at_last;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_hl_red   <= 8'd0;
            r_hl_green <= 8'd0;
            r_hl_blue  <= 8'd0;
            r_step_ms  <= DEF_STEP_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE: r_enable   <= i_cfg_data[0];
                REG_RED:    r_hl_red   <= i_cfg_data[7:0];
                REG_GREEN:  r_hl_green <= i_cfg_data[7:0];
                REG_BLUE:   r_hl_blue  <= i_cfg_data[7:0];
                REG_STEP:   r_step_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step decision and step time at frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_step <= 16'd0;
            r_do_step   <= 1'b0;
        end else if (i_cmd.frame_start) begin
            r_do_step <= elapsed > r_step_ms;
            if (elapsed > r_step_ms) begin
                r_last_step <= i_in.now_ms;
            end
        end
    end

    // cell walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= 2'd0;
            r_col  <= 4'd0;
            r_addr <= '0;
        end else if (i_cmd.frame_start) begin
            r_row  <= 2'd0;
            r_col  <= 4'd0;
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + AW'(1);
            if (r_col == 4'(COL_COUNT - 1)) begin
                r_col <= 4'd0;
                r_row <= r_row + 2'd1;
            end else begin
                r_col <= r_col + 4'd1;
            end
        end
    end

    // key press address and range check
    assign key_idx = 8'(i_in.key_row) * 8'(COL_COUNT) + 8'(i_in.key_col);
    assign key_hit = i_cmd.key_event && i_in.pressed
                     && (4'(i_in.key_row) < 4'(ROW_COUNT))
                     && (6'(i_in.key_col) < 6'(COL_COUNT));

    // decay of the cell in stage 1
    assign s1_level = r_s1_hit ? r_rd_data : 8'd0;
    assign s1_after = r_do_step ? decay(s1_level) : s1_level;
    assign s1_wr    = r_s1_valid && advance;

    // single write port: walk write-back or key press
    assign wr_en   = s1_wr || key_hit;
    assign wr_addr = s1_wr ? r_s1_addr : key_idx[AW-1:0];
    assign wr_data = s1_wr ? s1_after : LEVEL_FULL;

    // level memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // valid bits, cleared at once by reset or a clear action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_hit  <= r_vld[r_addr];
            r_s1_addr <= r_addr;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_last <= at_last;
        end
    end

    // stage 2: scale products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_prod_red   <= 16'(s1_level) * 16'(r_hl_red);
            r_prod_green <= 16'(s1_level) * 16'(r_hl_green);
            r_prod_blue  <= 16'(s1_level) * 16'(r_hl_blue);
            r_s2_black   <= (s1_level == 8'd0) || (s1_after == 8'd0);
            r_s2_row     <= r_s1_row;
            r_s2_col     <= r_s1_col;
            r_s2_last    <= r_s1_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.led_row <= r_s2_row;
            r_out.led_col <= r_s2_col;
            r_out.red     <= r_s2_black ? 8'd0 : div255(r_prod_red);
            r_out.green   <= r_s2_black ? 8'd0 : div255(r_prod_green);
            r_out.blue    <= r_s2_black ? 8'd0 : div255(r_prod_blue);
            r_out.last    <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/ktlfm_chk.sv */
// checker: port-level assertions for the key trail fade map, bound to the top level
`timescale 1ns / 1ps

module ktlfm_chk
    import ktlfm_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int COL_COUNT = DEF_COL_COUNT
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result item changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    // last flag marks exactly the final cell
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == ((o_out.led_row == 2'(ROW_COUNT - 1))
                                        && (o_out.led_col == 4'(COL_COUNT - 1)))))
        else $error("last flag on wrong cell");

    // the item after a frame's last cell starts a new frame
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.last
        |=> !o_out_valid || ((o_out.led_row == 2'd0) && (o_out.led_col == 4'd0)))
        else $error("frame does not start at the first cell");

endmodule

bind key_trail_led_fade_map ktlfm_chk #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
) u_ktlfm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
